// ----- rtl/core/pre_pkg.sv -----
// Shared types, constants and helpers of the printable run extractor.
`default_nettype none
package pre_pkg;

  // Longest run held in the buffer, and so the largest usable minimum.
  localparam int unsigned MAX_MIN_LEN     = 32;
  localparam int unsigned DEFAULT_MIN_LEN = 4;
  localparam int unsigned CNT_W  = $clog2(MAX_MIN_LEN + 1);
  localparam int unsigned BUF_AW = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;
  localparam int unsigned RESET_MIN =
    (DEFAULT_MIN_LEN > MAX_MIN_LEN) ? MAX_MIN_LEN : DEFAULT_MIN_LEN;

  localparam logic [7:0] TAB_CODE    = 8'h09;
  localparam logic [7:0] PRINT_LOW   = 8'h20;
  localparam logic [7:0] PRINT_HIGH  = 8'h7E;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIRECT,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_MARK
  } pre_state_t;

  // One result item on its way into the output register.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        item_kind;
    logic [31:0] string_start;
    logic        last_of_burst;
  } pre_item_t;

  function automatic logic is_printable(input logic [7:0] b);
    return ((b >= PRINT_LOW) && (b <= PRINT_HIGH)) || (b == TAB_CODE);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pre_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pre_outreg.sv -----
// Output register of the result stream: holds one item until it is taken.
`default_nettype none
module pre_outreg
  import pre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load_en,
  input  wire pre_item_t   load_item,
  output logic             free,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_byte [7:0], string_start [39:8]
  output logic             m_tuser,   // item_kind
  output logic             m_tlast
);

  pre_item_t item;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      item <= load_item;
    end
  end

  assign m_tdata = {item.string_start, item.out_byte};
  assign m_tuser = item.item_kind;
  assign m_tlast = item.last_of_burst;

endmodule
`default_nettype wire

// ----- rtl/core/printable_run_extractor.sv -----
// Top level of the printable run extractor: run tracking, buffer sequencer, ports.
// A pass-through byte goes through ST_DIRECT, and a lone end marker through ST_MARK, to
// the output register; a buffer dump of N bytes alternates ST_DUMP_RD (one buffer RAM
// read) and ST_DUMP_OUT (one output load) per byte, then ST_MARK for a trailing marker.
// Throughput: one item per cycle when it gives no result, otherwise the next item is
// taken once every result of the current one is in the output register.
// Reset clears run state, position, sequencer and minimum (to 4); the buffer RAM is not
// cleared, as an entry is only read after the current run wrote it.
`default_nettype none
module printable_run_extractor
  import pre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
  input  wire logic        s_tlast,   // stream_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_byte [7:0], string_start [39:8]
  output logic             m_tuser,   // item_kind
  output logic             m_tlast,   // last_of_burst
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data   // min_length
);

  // Run tracking state
  logic [CNT_W-1:0] run_count;
  logic             emitting;
  logic [31:0]      byte_position;
  logic [31:0]      run_start;
  logic [CNT_W-1:0] min_eff;

  // Sequencer
  pre_state_t       state, state_next;
  logic [7:0]       pend_byte;
  logic [CNT_W-1:0] dump_len;
  logic [CNT_W-1:0] idx;
  logic             mark_pend;

  logic             s_acc;
  logic             in_print;
  logic [CNT_W-1:0] cnt_step;
  logic             dump_go;
  logic             emit_now;
  logic             close_now;
  logic             mark_go;
  logic             dump_last;

  logic             out_free;
  logic             load_en;
  pre_item_t        load_item;
  logic             buf_wr_en;
  logic             buf_rd_en;
  logic [7:0]       buf_rd_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;

  // Classify the incoming byte against the current run.
  always_comb begin
    in_print  = is_printable(s_tdata);
    cnt_step  = (run_count < CNT_W'(MAX_MIN_LEN)) ? run_count + CNT_W'(1) : run_count;
    dump_go   = in_print && !emitting && (cnt_step >= min_eff);
    emit_now  = in_print && emitting;
    close_now = !in_print && emitting;
    // Stream end closes a string that is still open after this byte.
    mark_go   = s_tlast && in_print && (emitting || dump_go);
  end

  // Buffer the byte while the run is still below the minimum; drop it past capacity.
  assign buf_wr_en = s_acc && in_print && !emitting && (run_count < CNT_W'(MAX_MIN_LEN));

  pre_ram #(
    .WIDTH (8),
    .DEPTH (MAX_MIN_LEN)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (run_count[BUF_AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (buf_rd_en),
    .rd_addr (idx[BUF_AW-1:0]),
    .rd_data (buf_rd_data)
  );

  // Minimum length: clamp once at the write so the compare stays simple.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_eff <= CNT_W'(RESET_MIN);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == 6'd0) begin
        min_eff <= CNT_W'(1);
      end else if (cfg_data > 6'(MAX_MIN_LEN)) begin
        min_eff <= CNT_W'(MAX_MIN_LEN);
      end else begin
        min_eff <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // Run state: advance on each accepted item, clear at stream end.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count     <= '0;
      emitting      <= 1'b0;
      byte_position <= '0;
      run_start     <= '0;
    end else if (s_acc) begin
      if (in_print && !emitting && (run_count == '0)) begin
        run_start <= byte_position;
      end
      if (s_tlast) begin
        run_count     <= '0;
        emitting      <= 1'b0;
        byte_position <= '0;
      end else begin
        if (byte_position != '1) begin
          byte_position <= byte_position + 32'd1;
        end
        if (in_print) begin
          if (!emitting) begin
            run_count <= cnt_step;
            emitting  <= dump_go;
          end
        end else begin
          run_count <= '0;
          emitting  <= 1'b0;
        end
      end
    end
  end

  // Hold what the sequencer needs to play out this item's results.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      pend_byte <= s_tdata;
      dump_len  <= cnt_step;
      mark_pend <= mark_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (s_acc) begin
      idx <= '0;
    end else if ((state == ST_DUMP_OUT) && out_free) begin
      idx <= idx + CNT_W'(1);
    end
  end

  assign dump_last = ((idx + CNT_W'(1)) == dump_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next               = state;
    load_en                  = 1'b0;
    buf_rd_en                = 1'b0;
    load_item.out_byte       = pend_byte;
    load_item.item_kind      = KIND_BYTE;
    load_item.string_start   = run_start;
    load_item.last_of_burst  = !mark_pend;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (emit_now) begin
            state_next = ST_DIRECT;
          end else if (dump_go) begin
            state_next = ST_DUMP_RD;
          end else if (close_now) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_DIRECT: begin
        if (out_free) begin
          load_en    = 1'b1;
          state_next = mark_pend ? ST_MARK : ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        buf_rd_en  = 1'b1;
        state_next = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        load_item.out_byte      = buf_rd_data;
        load_item.last_of_burst = dump_last && !mark_pend;
        if (out_free) begin
          load_en = 1'b1;
          if (dump_last) begin
            state_next = mark_pend ? ST_MARK : ST_IDLE;
          end else begin
            state_next = ST_DUMP_RD;
          end
        end
      end
      ST_MARK: begin
        load_item.out_byte      = 8'h00;
        load_item.item_kind     = KIND_MARKER;
        load_item.last_of_burst = 1'b1;
        if (out_free) begin
          load_en    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  pre_outreg u_out (
    .clk       (clk),
    .rst       (rst),
    .load_en   (load_en),
    .load_item (load_item),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // An open string always has at least one buffered byte behind it.
  a_emit_has_run: assert property (@(posedge clk) disable iff (rst)
    emitting |-> (run_count != '0))
    else $error("emitting with an empty run");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= CNT_W'(MAX_MIN_LEN))
    else $error("run count past buffer capacity");

  a_dump_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP_RD || state == ST_DUMP_OUT) |-> (idx < dump_len))
    else $error("buffer dump index past dump length");

  a_end_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tlast) |=> ((byte_position == '0) && !emitting))
    else $error("stream end did not clear position and run");

endmodule
`default_nettype wire
